>>> hdl/sm83x_pkg.sv
`default_nettype none

package sm83x_pkg;

    // Request payload
    typedef struct packed {
        logic       req_type;
        logic [7:0] opcode;
        logic [7:0] imm_lo;
        logic [7:0] imm_hi;
        logic [7:0] read_data;
    } t_req;

    // Result payload
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] bus_addr;
        logic [7:0]  bus_data;
        logic [2:0]  cycle_count;
        logic        last;
        logic [15:0] pc_now;
        logic [15:0] reg_af;
        logic [15:0] reg_bc;
        logic [15:0] reg_de;
        logic [15:0] reg_hl;
        logic [15:0] stack_ptr;
    } t_res;

    // Architectural register file
    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  f;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic [15:0] sp;
        logic [15:0] pc;
        logic        pend;
    } t_arch;

    // Per-request control from the core to the result queue
    typedef struct packed {
        logic [1:0] push_cnt;
        logic       pend;
    } t_core_ctl;

    // Request kinds
    localparam logic REQ_EXEC = 1'b0;
    localparam logic REQ_RDATA = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_WRITE = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_UNIMP = 2'd3;

    // Opcodes
    localparam logic [7:0] OP_NOP       = 8'h00;
    localparam logic [7:0] OP_LD_BC_NN  = 8'h01;
    localparam logic [7:0] OP_LD_MBC_A  = 8'h02;
    localparam logic [7:0] OP_INC_BC    = 8'h03;
    localparam logic [7:0] OP_INC_B     = 8'h04;
    localparam logic [7:0] OP_DEC_B     = 8'h05;
    localparam logic [7:0] OP_LD_B_N    = 8'h06;
    localparam logic [7:0] OP_RLCA      = 8'h07;
    localparam logic [7:0] OP_LD_MNN_SP = 8'h08;
    localparam logic [7:0] OP_ADD_HL_BC = 8'h09;
    localparam logic [7:0] OP_LD_A_MBC  = 8'h0A;
    localparam logic [7:0] OP_DEC_BC    = 8'h0B;
    localparam logic [7:0] OP_INC_C     = 8'h0C;
    localparam logic [7:0] OP_DEC_C     = 8'h0D;
    localparam logic [7:0] OP_LD_C_N    = 8'h0E;
    localparam logic [7:0] OP_RRCA      = 8'h0F;
    localparam logic [7:0] OP_LD_DE_NN  = 8'h11;
    localparam logic [7:0] OP_LD_MDE_A  = 8'h12;
    localparam logic [7:0] OP_INC_DE    = 8'h13;
    localparam logic [7:0] OP_INC_D     = 8'h14;
    localparam logic [7:0] OP_DEC_D     = 8'h15;
    localparam logic [7:0] OP_LD_D_N    = 8'h16;
    localparam logic [7:0] OP_RLA       = 8'h17;
    localparam logic [7:0] OP_JR_E      = 8'h18;

    // Flag bit positions
    localparam int FLAG_Z = 7;
    localparam int FLAG_N = 6;
    localparam int FLAG_H = 5;
    localparam int FLAG_C = 4;

    // Register values after reset
    localparam logic [7:0]  RST_A  = 8'h01;
    localparam logic [7:0]  RST_F  = 8'hB0;
    localparam logic [15:0] RST_BC = 16'h0013;
    localparam logic [15:0] RST_DE = 16'h00D8;
    localparam logic [15:0] RST_HL = 16'h014D;
    localparam logic [15:0] RST_SP = 16'hFFFE;
    localparam logic [15:0] RST_PC = 16'h0100;

    // Result queue
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);
    // Highest fill count at which a request is still taken (worst case two results)
    localparam logic [QCW-1:0] QREADY_MAX = QCW'(QDEPTH - 2);

endpackage

`default_nettype wire

>>> hdl/sm83_opcode_subset_executor_unit.sv
`default_nettype none

// Channel   Signals                           Payload
// request   i_req_valid / o_req_ready         i_req (t_req)
// result    o_res_valid / i_res_ready         o_res (t_res)
//
// One request per cycle when ready; each result is queued in the cycle
// after its request. The SP store (opcode 0x08) yields two results.
// Requests are taken while the four-entry result queue has room for two.
// Synchronous active-low reset loads the post-boot register values.
// Results drain one per cycle while i_res_ready is high; none is lost.

module sm83_opcode_subset_executor_unit import sm83x_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_req i_req,
    output logic      o_res_valid,
    input  wire logic i_res_ready,
    output t_res      o_res
);

    logic           accept;
    t_core_ctl      ctl;
    t_res           res0;
    t_res           res1;
    logic [QCW-1:0] q_cnt;

    assign o_req_ready = (q_cnt <= QREADY_MAX);
    assign accept      = i_req_valid && o_req_ready;

    // Decode / register file
    sm83x_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .o_ctl    (ctl),
        .o_res0   (res0),
        .o_res1   (res1)
    );

    // Result queue
    sm83x_res_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (ctl.push_cnt),
        .i_res0     (res0),
        .i_res1     (res1),
        .o_valid    (o_res_valid),
        .i_ready    (i_res_ready),
        .o_res      (o_res),
        .o_cnt      (q_cnt)
    );

`ifndef SYNTHESIS
    // queue never overfills
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_cnt <= QCW'(QDEPTH))
        else $error("result queue overflow");

    // a request that pushes results makes a result visible next cycle
    a_push_vis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.push_cnt != 2'd0 |=> o_res_valid)
        else $error("pushed result not visible");

    // a load from (BC) arms the pending read
    a_pend_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req.req_type == REQ_EXEC && !ctl.pend
        && i_req.opcode == OP_LD_A_MBC |=> ctl.pend)
        else $error("pending read not set");

    // a request is dropped only when it mismatches the pending state
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && ctl.push_cnt == 2'd0 |->
        ((i_req.req_type == REQ_RDATA) != ctl.pend))
        else $error("request dropped unexpectedly");
`endif

endmodule

`default_nettype wire

>>> hdl/sm83x_core.sv
`default_nettype none

module sm83x_core import sm83x_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_accept,
    input  wire t_req      i_req,
    output t_core_ctl      o_ctl,
    output t_res           o_res0,
    output t_res           o_res1
);

    t_arch r_st;
    t_arch n_st;

    logic [1:0]  push_cnt;
    logic [1:0]  stat0;
    logic [15:0] addr0;
    logic [7:0]  data0;
    logic [2:0]  cyc;
    logic        last0;
    logic [15:0] word;
    logic [15:0] r8;
    logic [16:0] sum17;
    logic [12:0] sum13;

    // INC: result in [15:8], new flags in [7:0]
    function automatic logic [15:0] f_inc(input logic [7:0] v, input logic [7:0] f);
        logic [7:0] r;
        r = v + 8'd1;
        return {r, (r == 8'd0), 1'b0, (v[3:0] == 4'hF), f[FLAG_C], 4'b0000};
    endfunction

    // DEC: result in [15:8], new flags in [7:0]
    function automatic logic [15:0] f_dec(input logic [7:0] v, input logic [7:0] f);
        logic [7:0] r;
        r = v - 8'd1;
        return {r, (r == 8'd0), 1'b1, (v[3:0] == 4'h0), f[FLAG_C], 4'b0000};
    endfunction

    assign word  = {i_req.imm_hi, i_req.imm_lo};
    assign sum17 = {1'b0, r_st.hl} + {1'b0, r_st.bc};
    assign sum13 = {1'b0, r_st.hl[11:0]} + {1'b0, r_st.bc[11:0]};

    // Decode and next register state
    always_comb begin
        n_st     = r_st;
        push_cnt = 2'd1;
        stat0    = ST_DONE;
        addr0    = 16'h0000;
        data0    = 8'h00;
        cyc      = 3'd1;
        last0    = 1'b1;
        r8       = 16'h0000;
        if (i_req.req_type == REQ_RDATA) begin
            if (r_st.pend) begin
                n_st.a    = i_req.read_data;
                n_st.pend = 1'b0;
                cyc       = 3'd0;
            end else begin
                push_cnt = 2'd0;
            end
        end else if (r_st.pend) begin
            push_cnt = 2'd0;
        end else begin
            n_st.pc = r_st.pc + 16'd1;
            case (i_req.opcode)
                OP_NOP: begin
                end
                OP_LD_BC_NN: begin
                    n_st.bc = word;
                    n_st.pc = r_st.pc + 16'd3;
                    cyc     = 3'd3;
                end
                OP_LD_MBC_A: begin
                    stat0 = ST_WRITE;
                    addr0 = r_st.bc;
                    data0 = r_st.a;
                    cyc   = 3'd2;
                end
                OP_INC_BC: begin
                    n_st.bc = r_st.bc + 16'd1;
                    cyc     = 3'd2;
                end
                OP_INC_B: begin
                    r8         = f_inc(r_st.bc[15:8], r_st.f);
                    n_st.bc    = {r8[15:8], r_st.bc[7:0]};
                    n_st.f     = r8[7:0];
                end
                OP_DEC_B: begin
                    r8         = f_dec(r_st.bc[15:8], r_st.f);
                    n_st.bc    = {r8[15:8], r_st.bc[7:0]};
                    n_st.f     = r8[7:0];
                end
                OP_LD_B_N: begin
                    n_st.bc = {i_req.imm_lo, r_st.bc[7:0]};
                    n_st.pc = r_st.pc + 16'd2;
                    cyc     = 3'd2;
                end
                OP_RLCA: begin
                    n_st.a = {r_st.a[6:0], r_st.a[7]};
                    n_st.f = {3'b000, r_st.a[7], 4'b0000};
                end
                OP_LD_MNN_SP: begin
                    push_cnt = 2'd2;
                    n_st.pc  = r_st.pc + 16'd3;
                    stat0    = ST_WRITE;
                    addr0    = word;
                    data0    = r_st.sp[7:0];
                    cyc      = 3'd5;
                    last0    = 1'b0;
                end
                OP_ADD_HL_BC: begin
                    n_st.hl = sum17[15:0];
                    n_st.f  = {r_st.f[FLAG_Z], 1'b0, sum13[12], sum17[16], 4'b0000};
                    cyc     = 3'd2;
                end
                OP_LD_A_MBC: begin
                    n_st.pend = 1'b1;
                    stat0     = ST_READ;
                    addr0     = r_st.bc;
                    cyc       = 3'd2;
                end
                OP_DEC_BC: begin
                    n_st.bc = r_st.bc - 16'd1;
                    cyc     = 3'd2;
                end
                OP_INC_C: begin
                    r8      = f_inc(r_st.bc[7:0], r_st.f);
                    n_st.bc = {r_st.bc[15:8], r8[15:8]};
                    n_st.f  = r8[7:0];
                end
                OP_DEC_C: begin
                    r8      = f_dec(r_st.bc[7:0], r_st.f);
                    n_st.bc = {r_st.bc[15:8], r8[15:8]};
                    n_st.f  = r8[7:0];
                end
                OP_LD_C_N: begin
                    n_st.bc = {r_st.bc[15:8], i_req.imm_lo};
                    n_st.pc = r_st.pc + 16'd2;
                    cyc     = 3'd2;
                end
                OP_RRCA: begin
                    n_st.a = {r_st.a[0], r_st.a[7:1]};
                    n_st.f = {3'b000, r_st.a[0], 4'b0000};
                end
                OP_LD_DE_NN: begin
                    n_st.de = word;
                    n_st.pc = r_st.pc + 16'd3;
                    cyc     = 3'd3;
                end
                OP_LD_MDE_A: begin
                    stat0 = ST_WRITE;
                    addr0 = r_st.de;
                    data0 = r_st.a;
                    cyc   = 3'd2;
                end
                OP_INC_DE: begin
                    n_st.de = r_st.de + 16'd1;
                    cyc     = 3'd2;
                end
                OP_INC_D: begin
                    r8      = f_inc(r_st.de[15:8], r_st.f);
                    n_st.de = {r8[15:8], r_st.de[7:0]};
                    n_st.f  = r8[7:0];
                end
                OP_DEC_D: begin
                    r8      = f_dec(r_st.de[15:8], r_st.f);
                    n_st.de = {r8[15:8], r_st.de[7:0]};
                    n_st.f  = r8[7:0];
                end
                OP_LD_D_N: begin
                    n_st.de = {i_req.imm_lo, r_st.de[7:0]};
                    n_st.pc = r_st.pc + 16'd2;
                    cyc     = 3'd2;
                end
                OP_RLA: begin
                    n_st.a = {r_st.a[6:0], r_st.f[FLAG_C]};
                    n_st.f = {3'b000, r_st.a[7], 4'b0000};
                end
                OP_JR_E: begin
                    // signed 8-bit offset relative to the next instruction
                    n_st.pc = r_st.pc + 16'd2 + {{8{i_req.imm_lo[7]}}, i_req.imm_lo};
                    cyc     = 3'd3;
                end
                default: begin
                    // STOP and anything beyond the subset
                    stat0 = ST_UNIMP;
                    cyc   = 3'd0;
                end
            endcase
        end
    end

    // Results carry the register file after the step
    always_comb begin
        o_res0.status      = stat0;
        o_res0.bus_addr    = addr0;
        o_res0.bus_data    = data0;
        o_res0.cycle_count = cyc;
        o_res0.last        = last0;
        o_res0.pc_now      = n_st.pc;
        o_res0.reg_af      = {n_st.a, n_st.f};
        o_res0.reg_bc      = n_st.bc;
        o_res0.reg_de      = n_st.de;
        o_res0.reg_hl      = n_st.hl;
        o_res0.stack_ptr   = n_st.sp;

        // second write of the SP store: high byte at address plus one
        o_res1          = o_res0;
        o_res1.bus_addr = word + 16'd1;
        o_res1.bus_data = r_st.sp[15:8];
        o_res1.last     = 1'b1;
    end

    assign o_ctl.push_cnt = i_accept ? push_cnt : 2'd0;
    assign o_ctl.pend     = r_st.pend;

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.a    <= RST_A;
            r_st.f    <= RST_F;
            r_st.bc   <= RST_BC;
            r_st.de   <= RST_DE;
            r_st.hl   <= RST_HL;
            r_st.sp   <= RST_SP;
            r_st.pc   <= RST_PC;
            r_st.pend <= 1'b0;
        end else if (i_accept) begin
            r_st <= n_st;
        end
    end

endmodule

`default_nettype wire

>>> hdl/sm83x_res_fifo.sv
`default_nettype none

module sm83x_res_fifo import sm83x_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [1:0]     i_push_cnt,
    input  wire t_res           i_res0,
    input  wire t_res           i_res1,
    output logic                o_valid,
    input  wire logic           i_ready,
    output t_res                o_res,
    output logic [QCW-1:0]      o_cnt
);

    t_res           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QCW-1:0] r_cnt;
    logic [QAW-1:0] n_wptr;
    logic [QCW-1:0] n_cnt;
    logic [QAW-1:0] wptr1;
    logic           pop;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rptr];
    assign o_cnt   = r_cnt;
    assign pop     = o_valid && i_ready;
    assign wptr1   = r_wptr + QAW'(1);

    assign n_wptr = r_wptr + QAW'(i_push_cnt);
    assign n_cnt  = r_cnt + QCW'(i_push_cnt) - QCW'(pop);

    // Entry storage: up to two writes per cycle
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            if (i_push_cnt != 2'd0 && r_wptr == QAW'(i)) begin
                r_mem[i] <= i_res0;
            end else if (i_push_cnt == 2'd2 && wptr1 == QAW'(i)) begin
                r_mem[i] <= i_res1;
            end
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_cnt  <= n_cnt;
            if (pop) begin
                r_rptr <= r_rptr + QAW'(1);
            end
        end
    end

endmodule

`default_nettype wire
